>>> hw/rtl/ntp_pkg.sv
// Shared types, character codes and digit decoding for the number token parser.
package ntp_pkg;

  // Character codes
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  localparam logic [5:0] DecBase = 6'd10;
  localparam logic [5:0] MinBase = 6'd2;
  localparam logic [5:0] MaxBase = 6'd36;
  localparam logic [7:0] FracCountMax = 8'd255;

  localparam int unsigned AccWidthDefault = 32;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_SIGN       = 4'd1,
    PH_WHOLE      = 4'd2,
    PH_FRAC       = 4'd3,
    PH_RADIX      = 4'd4,
    PH_EXP_START  = 4'd5,
    PH_EXP_SIGN   = 4'd6,
    PH_EXP_DIGITS = 4'd7,
    PH_BAD        = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_INT     = 2'd1,
    KIND_REAL    = 2'd2
  } kind_e;

  // Parser control state (accumulators travel separately, their width is a parameter)
  typedef struct packed {
    phase_e      phase;
    logic        mant_negative;
    logic        exp_negative;
    logic        digit_seen;
    logic [5:0]  radix;
    logic [7:0]  frac_count;
  } ctrl_t;

  localparam ctrl_t CtrlInit = '{
    phase:         PH_START,
    mant_negative: 1'b0,
    exp_negative:  1'b0,
    digit_seen:    1'b0,
    radix:         DecBase,
    frac_count:    8'd0
  };

  // One result item
  typedef struct packed {
    logic [31:0] exponent;
    logic [7:0]  frac_digits;
    logic [31:0] frac_value;
    logic [31:0] whole_part;
    logic        negative;
    logic [31:0] int_value;
    kind_e       kind;
  } result_t;

  // Decoded digit: value 0..35 and a valid flag
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t r;
    logic [7:0] t;
    r = '{valid: 1'b0, value: 6'd0};
    t = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      r.valid = 1'b1;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      t = c - ChLowA + 8'd10;
      r.valid = 1'b1;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      t = c - ChUpA + 8'd10;
      r.valid = 1'b1;
    end
    r.value = t[5:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/ntp_step.sv
// One parse step: next parser state and the result item for one character.
module ntp_step #(
  parameter int unsigned ACC_WIDTH = ntp_pkg::AccWidthDefault
) (
  input  logic [7:0]           ch_i,
  input  logic                 last_i,
  input  ntp_pkg::ctrl_t       ctrl_i,
  input  logic [ACC_WIDTH-1:0] whole_i,
  input  logic [ACC_WIDTH-1:0] frac_i,
  input  logic [ACC_WIDTH-1:0] exp_i,
  output ntp_pkg::ctrl_t       ctrl_o,
  output logic [ACC_WIDTH-1:0] whole_o,
  output logic [ACC_WIDTH-1:0] frac_o,
  output logic [ACC_WIDTH-1:0] exp_o,
  output ntp_pkg::result_t     result_o
);

  // Zero-extend or truncate an accumulator to a 32-bit field
  function automatic logic [31:0] to32(input logic [ACC_WIDTH-1:0] v);
    logic [ACC_WIDTH+31:0] w;
    w = (ACC_WIDTH + 32)'(v);
    return w[31:0];
  endfunction

  ntp_pkg::digit_t       dig;
  logic                  dec;
  logic                  is_e;
  logic                  is_sign;
  logic [ACC_WIDTH-1:0]  dig_acc;
  logic [ACC_WIDTH-1:0]  whole_mac;
  logic [ACC_WIDTH-1:0]  frac_mac;
  logic [ACC_WIDTH-1:0]  exp_mac;
  ntp_pkg::ctrl_t        c_n;
  logic [ACC_WIDTH-1:0]  whole_n;
  logic [ACC_WIDTH-1:0]  frac_n;
  logic [ACC_WIDTH-1:0]  exp_n;
  ntp_pkg::kind_e        kind;

  // Character classes
  assign dig     = ntp_pkg::digit_of(ch_i);
  assign dec     = dig.valid && (dig.value < ntp_pkg::DecBase);
  assign is_e    = (ch_i == ntp_pkg::ChLowE) || (ch_i == ntp_pkg::ChUpE);
  assign is_sign = (ch_i == ntp_pkg::ChPlus) || (ch_i == ntp_pkg::ChMinus);
  assign dig_acc = ACC_WIDTH'(dig.value);

  // Multiply-accumulate, wrapping at ACC_WIDTH; radix holds ten in the decimal phases
  assign whole_mac = ACC_WIDTH'(whole_i * ACC_WIDTH'(ctrl_i.radix)) + dig_acc;
  assign frac_mac  = ACC_WIDTH'(frac_i * ACC_WIDTH'(ntp_pkg::DecBase)) + dig_acc;
  assign exp_mac   = ACC_WIDTH'(exp_i * ACC_WIDTH'(ntp_pkg::DecBase)) + dig_acc;

  // Phase transitions
  always_comb begin
    c_n     = ctrl_i;
    whole_n = whole_i;
    frac_n  = frac_i;
    exp_n   = exp_i;
    case (ctrl_i.phase)
      ntp_pkg::PH_START, ntp_pkg::PH_SIGN: begin
        if (ctrl_i.phase == ntp_pkg::PH_START && is_sign) begin
          c_n.mant_negative = (ch_i == ntp_pkg::ChMinus);
          c_n.phase = ntp_pkg::PH_SIGN;
        end else if (dec) begin
          whole_n = dig_acc;
          c_n.digit_seen = 1'b1;
          c_n.phase = ntp_pkg::PH_WHOLE;
        end else if (ch_i == ntp_pkg::ChPoint) begin
          c_n.phase = ntp_pkg::PH_FRAC;
        end else begin
          c_n.phase = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_WHOLE: begin
        if (dec) begin
          whole_n = whole_mac;
        end else if (ch_i == ntp_pkg::ChPoint) begin
          c_n.phase = ntp_pkg::PH_FRAC;
        end else if (ch_i == ntp_pkg::ChHash) begin
          if (whole_i >= ACC_WIDTH'(ntp_pkg::MinBase) &&
              whole_i <= ACC_WIDTH'(ntp_pkg::MaxBase)) begin
            c_n.radix = whole_i[5:0];
            whole_n = '0;
            c_n.digit_seen = 1'b0;
            c_n.phase = ntp_pkg::PH_RADIX;
          end else begin
            c_n.phase = ntp_pkg::PH_BAD;
          end
        end else if (is_e) begin
          c_n.phase = ntp_pkg::PH_EXP_START;
        end else begin
          c_n.phase = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_FRAC: begin
        if (dec) begin
          frac_n = frac_mac;
          if (ctrl_i.frac_count != ntp_pkg::FracCountMax) begin
            c_n.frac_count = ctrl_i.frac_count + 8'd1;
          end
          c_n.digit_seen = 1'b1;
        end else if (is_e && ctrl_i.digit_seen) begin
          c_n.phase = ntp_pkg::PH_EXP_START;
        end else begin
          c_n.phase = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_RADIX: begin
        if (dig.valid && dig.value < ctrl_i.radix) begin
          whole_n = whole_mac;
          c_n.digit_seen = 1'b1;
        end else begin
          c_n.phase = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_EXP_START, ntp_pkg::PH_EXP_SIGN: begin
        if (ctrl_i.phase == ntp_pkg::PH_EXP_START && is_sign) begin
          c_n.exp_negative = (ch_i == ntp_pkg::ChMinus);
          c_n.phase = ntp_pkg::PH_EXP_SIGN;
        end else if (dec) begin
          exp_n = dig_acc;
          c_n.phase = ntp_pkg::PH_EXP_DIGITS;
        end else begin
          c_n.phase = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_EXP_DIGITS: begin
        if (dec) begin
          exp_n = exp_mac;
        end else begin
          c_n.phase = ntp_pkg::PH_BAD;
        end
      end
      default: begin
        c_n.phase = ntp_pkg::PH_BAD;
      end
    endcase
  end

  // Classify the token as it stands after this character
  always_comb begin
    if (c_n.phase == ntp_pkg::PH_WHOLE ||
        (c_n.phase == ntp_pkg::PH_RADIX && c_n.digit_seen)) begin
      kind = ntp_pkg::KIND_INT;
    end else if ((c_n.phase == ntp_pkg::PH_FRAC && c_n.digit_seen) ||
                 c_n.phase == ntp_pkg::PH_EXP_DIGITS) begin
      kind = ntp_pkg::KIND_REAL;
    end else begin
      kind = ntp_pkg::KIND_INVALID;
    end
  end

  // Result fields; unused fields stay zero
  always_comb begin
    result_o = '0;
    result_o.kind = kind;
    case (kind)
      ntp_pkg::KIND_INT: begin
        result_o.int_value = to32(c_n.mant_negative ? (ACC_WIDTH'(0) - whole_n) : whole_n);
        result_o.negative  = c_n.mant_negative;
      end
      ntp_pkg::KIND_REAL: begin
        result_o.negative    = c_n.mant_negative;
        result_o.whole_part  = to32(whole_n);
        result_o.frac_value  = to32(frac_n);
        result_o.frac_digits = c_n.frac_count;
        result_o.exponent    = to32(c_n.exp_negative ? (ACC_WIDTH'(0) - exp_n) : exp_n);
      end
      default: begin
        result_o.kind = ntp_pkg::KIND_INVALID;
      end
    endcase
  end

  // A token's last character returns the parser to its start state
  assign ctrl_o  = last_i ? ntp_pkg::CtrlInit : c_n;
  assign whole_o = last_i ? '0 : whole_n;
  assign frac_o  = last_i ? '0 : frac_n;
  assign exp_o   = last_i ? '0 : exp_n;

endmodule

>>> hw/rtl/numeric_token_parser_unit.sv
// Number token parser top level: input register, parser state and result register.
//
// Usage: characters of a number token enter on the s_axis channel, one per
// item, ch in tdata[7:0] and tlast high on the token's final character.
// For each token one result item leaves on m_axis, carrying the kind
// (invalid, integer, real) on tuser and the integer or real parts on tdata.
// Result path: the input register takes the final character at its accepting
// edge, and the result register loads the result item from it when the parse
// step fires, which a stuck result on m_axis can delay.
// Throughput: one character per cycle while no final character waits on a
// stuck result; the per-character multiply-accumulate and phase update sit
// between the input register and the parser state registers.
// Reset: rst_ni clears the parser to its token-start state and drops both
// valid flags; no clearing pass is needed.
// Stall: while m_axis_tready is low a pending result holds; characters that
// end no token keep flowing, and a final character waits in the input
// register, holding s_axis_tready low, until the result register frees.
module numeric_token_parser_unit #(
  parameter int unsigned ACC_WIDTH = ntp_pkg::AccWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] int_value, [32] negative, [64:33] whole_part, [96:65] frac_value,
  // [104:97] frac_digits, [136:105] exponent, [143:137] zero
  output logic [143:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] kind
);

  logic                 in_valid_q;
  logic [7:0]           ch_q;
  logic                 last_q;
  logic                 step_fire;
  logic                 in_fire;
  ntp_pkg::ctrl_t       ctrl_q, ctrl_d;
  logic [ACC_WIDTH-1:0] whole_q, whole_d;
  logic [ACC_WIDTH-1:0] frac_q, frac_d;
  logic [ACC_WIDTH-1:0] exp_q, exp_d;
  ntp_pkg::result_t     result_d;
  ntp_pkg::result_t     out_q;
  logic                 out_valid_q;

  // Handshake: a character is processed unless it ends a token while a result is stuck
  assign step_fire     = in_valid_q && (!last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q   <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // Parse step
  ntp_step #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_step (
    .ch_i     (ch_q),
    .last_i   (last_q),
    .ctrl_i   (ctrl_q),
    .whole_i  (whole_q),
    .frac_i   (frac_q),
    .exp_i    (exp_q),
    .ctrl_o   (ctrl_d),
    .whole_o  (whole_d),
    .frac_o   (frac_d),
    .exp_o    (exp_d),
    .result_o (result_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= ntp_pkg::CtrlInit;
      whole_q <= '0;
      frac_q  <= '0;
      exp_q   <= '0;
    end else if (step_fire) begin
      ctrl_q  <= ctrl_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      exp_q   <= exp_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && last_q) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.exponent, out_q.frac_digits, out_q.frac_value,
                          out_q.whole_part, out_q.negative, out_q.int_value};
  assign m_axis_tuser  = out_q.kind;

  // A token's final character always produces a result item
  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && last_q |=> out_valid_q)
    else $error("final character did not load a result");

  // The parser is back at token start after each result
  a_state_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && last_q |=> ctrl_q.phase == ntp_pkg::PH_START && whole_q == '0 &&
                           frac_q == '0 && exp_q == '0)
    else $error("parser state not cleared after a token");

  // In the decimal phases the base is ten
  a_radix_decimal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == ntp_pkg::PH_START || ctrl_q.phase == ntp_pkg::PH_SIGN ||
     ctrl_q.phase == ntp_pkg::PH_WHOLE || ctrl_q.phase == ntp_pkg::PH_FRAC)
    |-> ctrl_q.radix == ntp_pkg::DecBase)
    else $error("radix is not ten in a decimal phase");

  // An empty input register never back-pressures the sender
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty input register");

endmodule

>>> tb/numeric_token_parser_unit_test.sv
// Self-checking stream testbench for the number token parser: directed and random tokens.
module numeric_token_parser_unit_test;

  localparam int unsigned CharTarget = 950;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned NoDigit    = 99;
  localparam int unsigned TailCycles = 20;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       drain;  // wait for every token result before offering this char
  } char_item_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;   // [7:0] ch
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [31:0] int_value, [32] negative, [64:33] whole_part, [96:65] frac_value,
  // [104:97] frac_digits, [136:105] exponent, [143:137] zero
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;          // [1:0] kind

  numeric_token_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  char_item_t          chars_to_send[$];
  ntp_pkg::result_t    expected_results[$];
  logic [7:0]          tok[$];
  int unsigned         chars_made = 0;
  int unsigned         tokens_issued = 0;
  int unsigned         tokens_got = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  int unsigned         send_gap = 0;
  bit                  send_calm = 1'b0;
  int unsigned         stall_left = 0;
  int unsigned         hold_left = 0;
  int unsigned         long_holds = 0;
  bit                  recv_calm = 1'b0;

  // Parser state mirror
  ntp_pkg::phase_e     ph;
  logic                neg_mant, neg_exp, seen;
  logic [5:0]          base;
  logic [31:0]         whole, frac, expo;
  logic [7:0]          nfrac;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Digit value 0..35 of a character, NoDigit when it is not alphanumeric
  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c >= ntp_pkg::ChZero && c <= ntp_pkg::ChNine) return 32'(c - ntp_pkg::ChZero);
    if (c >= ntp_pkg::ChLowA && c <= ntp_pkg::ChLowZ) return c - ntp_pkg::ChLowA + 10;
    if (c >= ntp_pkg::ChUpA && c <= ntp_pkg::ChUpZ) return c - ntp_pkg::ChUpA + 10;
    return NoDigit;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic clear_parse();
    ph = ntp_pkg::PH_START;
    neg_mant = 1'b0;
    neg_exp = 1'b0;
    seen = 1'b0;
    base = ntp_pkg::DecBase;
    whole = '0;
    frac = '0;
    expo = '0;
    nfrac = '0;
  endtask

  // Advance the parser mirror by one char; on the final char queue the result
  task automatic parse_char(input logic [7:0] c, input logic fin);
    int unsigned dv;
    logic is_dec, is_exp, is_sgn;
    ntp_pkg::result_t r;
    dv = char_digit(c);
    is_dec = dv < 10;
    is_exp = (c == ntp_pkg::ChLowE) || (c == ntp_pkg::ChUpE);
    is_sgn = (c == ntp_pkg::ChPlus) || (c == ntp_pkg::ChMinus);
    case (ph)
      ntp_pkg::PH_START, ntp_pkg::PH_SIGN: begin
        if (ph == ntp_pkg::PH_START && is_sgn) begin
          neg_mant = (c == ntp_pkg::ChMinus);
          ph = ntp_pkg::PH_SIGN;
        end else if (is_dec) begin
          whole = dv;
          seen = 1'b1;
          ph = ntp_pkg::PH_WHOLE;
        end else if (c == ntp_pkg::ChPoint) begin
          ph = ntp_pkg::PH_FRAC;
        end else begin
          ph = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_WHOLE: begin
        if (is_dec) begin
          whole = whole * 32'd10 + dv;
        end else if (c == ntp_pkg::ChPoint) begin
          ph = ntp_pkg::PH_FRAC;
        end else if (c == ntp_pkg::ChHash) begin
          if (whole >= 32'(ntp_pkg::MinBase) && whole <= 32'(ntp_pkg::MaxBase)) begin
            base = whole[5:0];
            whole = '0;
            seen = 1'b0;
            ph = ntp_pkg::PH_RADIX;
          end else begin
            ph = ntp_pkg::PH_BAD;
          end
        end else if (is_exp) begin
          ph = ntp_pkg::PH_EXP_START;
        end else begin
          ph = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_FRAC: begin
        if (is_dec) begin
          frac = frac * 32'd10 + dv;
          if (nfrac != ntp_pkg::FracCountMax) nfrac++;
          seen = 1'b1;
        end else if (is_exp && seen) begin
          ph = ntp_pkg::PH_EXP_START;
        end else begin
          ph = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_RADIX: begin
        if (dv < 32'(base)) begin
          whole = whole * 32'(base) + dv;
          seen = 1'b1;
        end else begin
          ph = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_EXP_START, ntp_pkg::PH_EXP_SIGN: begin
        if (ph == ntp_pkg::PH_EXP_START && is_sgn) begin
          neg_exp = (c == ntp_pkg::ChMinus);
          ph = ntp_pkg::PH_EXP_SIGN;
        end else if (is_dec) begin
          expo = dv;
          ph = ntp_pkg::PH_EXP_DIGITS;
        end else begin
          ph = ntp_pkg::PH_BAD;
        end
      end
      ntp_pkg::PH_EXP_DIGITS: begin
        if (is_dec) expo = expo * 32'd10 + dv;
        else ph = ntp_pkg::PH_BAD;
      end
      default: ph = ntp_pkg::PH_BAD;
    endcase
    if (fin) begin
      r = '0;
      if (ph == ntp_pkg::PH_WHOLE || (ph == ntp_pkg::PH_RADIX && seen)) begin
        r.kind = ntp_pkg::KIND_INT;
      end else if ((ph == ntp_pkg::PH_FRAC && seen) || ph == ntp_pkg::PH_EXP_DIGITS) begin
        r.kind = ntp_pkg::KIND_REAL;
      end else begin
        r.kind = ntp_pkg::KIND_INVALID;
      end
      if (r.kind == ntp_pkg::KIND_INT) begin
        r.int_value = neg_mant ? 32'd0 - whole : whole;
        r.negative = neg_mant;
      end else if (r.kind == ntp_pkg::KIND_REAL) begin
        r.negative = neg_mant;
        r.whole_part = whole;
        r.frac_value = frac;
        r.frac_digits = nfrac;
        r.exponent = neg_exp ? 32'd0 - expo : expo;
      end
      expected_results.push_back(r);
      clear_parse();
    end
  endtask

  // Move the token under construction into the send queue
  task automatic push_token(input bit drain);
    for (int i = 0; i < tok.size(); i++) begin
      chars_to_send.push_back('{ch: tok[i], fin: (i == tok.size() - 1), drain: drain && i == 0});
    end
    chars_made += tok.size();
    tok.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    push_token(1'b0);
  endtask

  function automatic logic [7:0] dec_char();
    return 8'(ntp_pkg::ChZero + $urandom_range(9));
  endfunction

  // A digit below b, letters in random case
  function automatic logic [7:0] base_char(input int unsigned b);
    int unsigned v;
    v = $urandom_range(b - 1);
    if (v < 10) return 8'(ntp_pkg::ChZero + v);
    return $urandom_range(1) ? 8'(ntp_pkg::ChLowA + v - 10) : 8'(ntp_pkg::ChUpA + v - 10);
  endfunction

  function automatic logic [7:0] junk_char();
    case ($urandom_range(5))
      0: return ntp_pkg::ChPoint;
      1: return ntp_pkg::ChHash;
      2: return ntp_pkg::ChLowE;
      3: return ntp_pkg::ChMinus;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed token with random content: integer, radix integer or real
  task automatic make_good();
    int unsigned n, b, sgn;
    bit dotted;
    sgn = $urandom_range(2);
    if (sgn == 1) tok.push_back(ntp_pkg::ChPlus);
    else if (sgn == 2) tok.push_back(ntp_pkg::ChMinus);
    case ($urandom_range(2))
      0: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 11) : $urandom_range(10, 1);
        repeat (n) tok.push_back(dec_char());
      end
      1: begin
        b = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(36, 2);
        if (b >= 10) tok.push_back(8'(ntp_pkg::ChZero + b / 10));
        tok.push_back(8'(ntp_pkg::ChZero + b % 10));
        tok.push_back(ntp_pkg::ChHash);
        n = ($urandom_range(9) == 0) ? 20 : $urandom_range(8, 1);
        repeat (n) tok.push_back((b >= 2 && b <= 36) ? base_char(b) : base_char(36));
      end
      default: begin
        dotted = $urandom_range(4) != 0;
        n = dotted ? $urandom_range(4) : $urandom_range(4, 1);
        repeat (n) tok.push_back(dec_char());
        if (dotted) begin
          tok.push_back(ntp_pkg::ChPoint);
          n = $urandom_range(6);
          repeat (n) tok.push_back(dec_char());
        end
        if (!dotted || $urandom_range(1)) begin
          tok.push_back($urandom_range(1) ? ntp_pkg::ChLowE : ntp_pkg::ChUpE);
          sgn = $urandom_range(2);
          if (sgn == 1) tok.push_back(ntp_pkg::ChPlus);
          else if (sgn == 2) tok.push_back(ntp_pkg::ChMinus);
          n = ($urandom_range(7) == 0) ? 12 : $urandom_range(4, 1);
          repeat (n) tok.push_back(dec_char());
        end
      end
    endcase
  endtask

  // Random token: mostly well formed, some corrupted, some pure noise
  task automatic make_random();
    int unsigned r, pos, n;
    r = $urandom_range(99);
    if (r < 85) begin
      make_good();
      if (r >= 70) begin
        case ($urandom_range(2))
          0: begin
            pos = $urandom_range(tok.size() - 1);
            tok[pos] = junk_char();
          end
          1: if (tok.size() > 1) begin
            n = $urandom_range(tok.size() - 1, 1);
            while (tok.size() > n) void'(tok.pop_back());
          end
          default: tok.push_back(junk_char());
        endcase
      end
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) tok.push_back(junk_char());
    end
  endtask

  // Sender: offers queued chars, predicts each accepted one
  always @(posedge clk_i) begin
    char_item_t nxt;
    logic fired, fin_taken;
    int unsigned owed;
    if (rst_ni) begin
      fired = s_axis_tvalid && s_axis_tready;
      fin_taken = fired && s_axis_tlast;
      if (fired) parse_char(s_axis_tdata, s_axis_tlast);
      if (fin_taken) tokens_issued <= tokens_issued + 1;
      owed = tokens_issued - tokens_got + (fin_taken ? 1 : 0);
      if (fired || !s_axis_tvalid) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (chars_to_send.size() > 0 && !(chars_to_send[0].drain && owed != 0)) begin
          nxt = chars_to_send.pop_front();
          s_axis_tdata <= nxt.ch;
          s_axis_tlast <= nxt.fin;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(99) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that back up the input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left == 0 && long_holds < 2 && tokens_got >= (long_holds == 0 ? 25 : 100)) begin
        hold_left = LongHold;
        long_holds++;
      end
      if ($urandom_range(199) == 0) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!recv_calm && $urandom_range(99) < 25) stall_left = idle_len();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    ntp_pkg::result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = ntp_pkg::result_t'({m_axis_tdata[136:0], m_axis_tuser});
      tokens_got <= tokens_got + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("int_value", want.int_value, got.int_value);
        check_field("negative", 32'(want.negative), 32'(got.negative));
        check_field("whole_part", want.whole_part, got.whole_part);
        check_field("frac_value", want.frac_value, got.frac_value);
        check_field("frac_digits", 32'(want.frac_digits), 32'(got.frac_digits));
        check_field("exponent", want.exponent, got.exponent);
        check_field("padding", 32'd0, 32'(m_axis_tdata[143:137]));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned ntok;
    clear_parse();
    // Directed: extremes, every form and the invalid corners
    queue_text("0");
    queue_text("-1");
    queue_text("36#Zz");
    queue_text("1.");
    queue_text(".");
    queue_text("+");
    queue_text("-.5E-3");
    queue_text("2#2");
    queue_text("1e");
    queue_text("1#1");
    queue_text("8#");
    queue_text("9e9x");
    // Random tokens; one very long fraction to saturate the digit count
    ntok = 0;
    while (chars_made < CharTarget) begin
      if (ntok == 30) begin
        tok.push_back(8'(ntp_pkg::ChZero + 1));
        tok.push_back(ntp_pkg::ChPoint);
        repeat (260) tok.push_back(dec_char());
      end else begin
        make_random();
      end
      push_token(ntok == 50 || $urandom_range(49) == 0);
      ntok++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (chars_to_send.size() != 0 || s_axis_tvalid || tokens_issued != tokens_got);
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
